[sv/shtl_pkg.sv]
package shtl_pkg;

	localparam int ENTRIES  = 16;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int HANDLE_W = 64;
	localparam int SEC_W    = 32;
	localparam int MS_W     = 10;
	localparam int OP_W     = 2;
	localparam int SLOT_W   = 4;
	localparam int TIME_W   = SEC_W + MS_W;

	typedef enum logic [OP_W-1:0] {
		OP_START  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_ABORT  = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} sts_t;

endpackage

[sv/shtl_ctrl.sv]
module shtl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      opcode,
	output logic            in_ready,
	input  shtl_pkg::sts_t  sts,
	output shtl_pkg::cmd_t  cmd
);
	import shtl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (op_t'(opcode) != OP_IGNORE)) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(state_q) == ST_SCAN || $past(state_q) == ST_COMMIT)
		else $error("commit without a scan");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SCAN)
		else $error("load did not start a scan");

	a_no_load_during_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready && !cmd.load)
		else $error("item taken while busy");

endmodule

[sv/shtl_dp.sv]
module shtl_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  shtl_pkg::cmd_t                 cmd,
	output shtl_pkg::sts_t                 sts,
	input  logic [shtl_pkg::OP_W-1:0]      opcode,
	input  logic [shtl_pkg::HANDLE_W-1:0]  handle,
	input  logic [shtl_pkg::SEC_W-1:0]     now_seconds,
	input  logic [shtl_pkg::MS_W-1:0]      now_millis,
	input  logic                           timed_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           status,
	output logic [shtl_pkg::SLOT_W-1:0]    slot,
	output logic                           evicted,
	output logic [shtl_pkg::HANDLE_W-1:0]  evicted_handle,
	output logic                           timer_trigger
);
	import shtl_pkg::*;

	// entry store
	logic [ENTRIES-1:0]  entry_valid_q;
	logic [ENTRIES-1:0]  entry_timed_q;
	logic [HANDLE_W-1:0] entry_handle_q [ENTRIES];
	logic [TIME_W-1:0]   entry_time_q   [ENTRIES];

	// latched item
	op_t                 op_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [TIME_W-1:0]   time_q;
	logic                timed_q;

	// scan state
	logic [IDX_W-1:0]    cnt_q;
	logic                found_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic                match_timed_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [TIME_W-1:0]   best_time_q;
	logic [HANDLE_W-1:0] best_handle_q;
	logic                best_timed_q;

	// output register
	logic                out_valid_q;
	logic                status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                evicted_q;
	logic [HANDLE_W-1:0] evicted_handle_q;
	logic                timer_trigger_q;

	logic                rd_valid;
	logic                rd_timed;
	logic [HANDLE_W-1:0] rd_handle;
	logic [TIME_W-1:0]   rd_time;
	logic [IDX_W-1:0]    start_idx;

	assign rd_valid  = entry_valid_q[cnt_q];
	assign rd_timed  = entry_timed_q[cnt_q];
	assign rd_handle = entry_handle_q[cnt_q];
	assign rd_time   = entry_time_q[cnt_q];
	assign start_idx = free_found_q ? free_idx_q : best_idx_q;

	assign sts.scan_last = (cnt_q == IDX_W'(ENTRIES - 1));
	assign sts.out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(opcode);
			handle_q <= handle;
			time_q   <= {now_seconds, now_millis};
			timed_q  <= timed_key;
		end
		if (cmd.step) begin
			if (!found_q && rd_valid && (rd_handle == handle_q)) begin
				match_idx_q   <= cnt_q;
				match_timed_q <= rd_timed;
			end
			if (!free_found_q && !rd_valid) begin
				free_idx_q <= cnt_q;
			end
			if ((cnt_q == '0) || (rd_time < best_time_q)) begin
				best_idx_q    <= cnt_q;
				best_time_q   <= rd_time;
				best_handle_q <= rd_handle;
				best_timed_q  <= rd_timed;
			end
		end
		if (cmd.commit) begin
			unique case (op_q)
				OP_START: begin
					entry_handle_q[start_idx] <= handle_q;
					entry_time_q[start_idx]   <= time_q;
				end
				OP_LOOKUP: begin
					if (found_q) begin
						entry_time_q[match_idx_q] <= time_q;
					end
				end
				default: begin
				end
			endcase
			unique case (op_q) inside
				OP_START: begin
					status_q         <= 1'b0;
					slot_q           <= SLOT_W'(start_idx);
					evicted_q        <= !free_found_q;
					evicted_handle_q <= free_found_q ? '0 : best_handle_q;
					timer_trigger_q  <= !free_found_q && best_timed_q;
				end
				OP_LOOKUP, OP_ABORT: begin
					status_q         <= !found_q;
					slot_q           <= found_q ? SLOT_W'(match_idx_q) : '0;
					evicted_q        <= 1'b0;
					evicted_handle_q <= '0;
					timer_trigger_q  <= found_q && (op_q == OP_ABORT) && match_timed_q;
				end
				default: begin
					status_q         <= 1'b0;
					slot_q           <= '0;
					evicted_q        <= 1'b0;
					evicted_handle_q <= '0;
					timer_trigger_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			entry_timed_q <= '0;
			cnt_q         <= '0;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
				if (rd_valid && (rd_handle == handle_q)) begin
					found_q <= 1'b1;
				end
				if (!rd_valid) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				unique case (op_q)
					OP_START: begin
						entry_valid_q[start_idx] <= 1'b1;
						entry_timed_q[start_idx] <= timed_q;
					end
					OP_ABORT: begin
						if (found_q) begin
							entry_valid_q[match_idx_q] <= 1'b0;
							entry_timed_q[match_idx_q] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign slot           = slot_q;
	assign evicted        = evicted_q;
	assign evicted_handle = evicted_handle_q;
	assign timer_trigger  = timer_trigger_q;

	a_commit_into_free_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

	a_evict_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_START) && !free_found_q |-> &entry_valid_q)
		else $error("eviction with a free slot");

	a_start_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_START) |=> entry_valid_q[$past(start_idx)])
		else $error("start left slot empty");

	a_miss_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> !evicted_q && !timer_trigger_q && (slot_q == '0))
		else $error("miss result carries data");

endmodule

[sv/session_handle_table_lru.sv]
// channel  handshake            payload
// in       in_valid / in_ready  opcode, handle, now_seconds, now_millis, timed_key
// out      out_valid/out_ready  status, slot, evicted, evicted_handle, timer_trigger
//
// an item is taken in the idle state; the scan state then reads each table entry in turn,
// and the commit state updates the table and loads the result register
// an unused opcode is taken while idle and gives no result
// arst_n clears every valid and timed flag at once; no clearing pass
// the next item is taken while a result waits; its update waits until out_ready frees
// the result register
module session_handle_table_lru (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [shtl_pkg::OP_W-1:0]      opcode,
	input  logic [shtl_pkg::HANDLE_W-1:0]  handle,
	input  logic [shtl_pkg::SEC_W-1:0]     now_seconds,
	input  logic [shtl_pkg::MS_W-1:0]      now_millis,
	input  logic                           timed_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           status,
	output logic [shtl_pkg::SLOT_W-1:0]    slot,
	output logic                           evicted,
	output logic [shtl_pkg::HANDLE_W-1:0]  evicted_handle,
	output logic                           timer_trigger
);
	import shtl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	shtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	shtl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.handle         (handle),
		.now_seconds    (now_seconds),
		.now_millis     (now_millis),
		.timed_key      (timed_key),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot           (slot),
		.evicted        (evicted),
		.evicted_handle (evicted_handle),
		.timer_trigger  (timer_trigger)
	);

endmodule

[verif/tb_top.sv]
module tb_top;
	import shtl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_CYCLES = 3 * ENTRIES;

	typedef struct packed {
		logic                status;
		logic [SLOT_W-1:0]   slot;
		logic                evicted;
		logic [HANDLE_W-1:0] evicted_handle;
		logic                timer_trigger;
	} result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     opcode = OP_IGNORE;
	logic [HANDLE_W-1:0] handle = '0;
	logic [SEC_W-1:0]    now_seconds = '0;
	logic [MS_W-1:0]     now_millis = '0;
	logic                timed_key = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                status;
	logic [SLOT_W-1:0]   slot;
	logic                evicted;
	logic [HANDLE_W-1:0] evicted_handle;
	logic                timer_trigger;

	logic idle_on = 1'b1;
	logic long_hold = 1'b0;
	event hold_start;

	// predicted table contents
	logic                tbl_valid [ENTRIES];
	logic [HANDLE_W-1:0] tbl_handle [ENTRIES];
	logic [SEC_W-1:0]    tbl_sec [ENTRIES];
	logic [MS_W-1:0]     tbl_ms [ENTRIES];
	logic                tbl_timed [ENTRIES];

	result_t             pending_results [$];
	logic [HANDLE_W-1:0] handle_pool [$];
	logic [SEC_W-1:0]    clock_sec;

	int cycle_count = 0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int evictions_seen = 0;
	int misses_seen = 0;
	int triggers_seen = 0;

	session_handle_table_lru dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.handle         (handle),
		.now_seconds    (now_seconds),
		.now_millis     (now_millis),
		.timed_key      (timed_key),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot           (slot),
		.evicted        (evicted),
		.evicted_handle (evicted_handle),
		.timer_trigger  (timer_trigger)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic bit predict_table(input op_t op, input logic [HANDLE_W-1:0] h,
		input logic [SEC_W-1:0] sec, input logic [MS_W-1:0] ms, input logic tk,
		output result_t res);
		int idx;
		res = '0;
		idx = -1;
		if (op == OP_IGNORE)
			return 0;
		if (op == OP_START) begin
			for (int i = 0; i < ENTRIES; i++)
				if (!tbl_valid[i] && idx < 0)
					idx = i;
			if (idx < 0) begin
				idx = 0;
				for (int i = 1; i < ENTRIES; i++)
					if ({tbl_sec[i], tbl_ms[i]} < {tbl_sec[idx], tbl_ms[idx]})
						idx = i;
				res.evicted = 1'b1;
				res.evicted_handle = tbl_handle[idx];
				res.timer_trigger = tbl_timed[idx];
			end
			tbl_valid[idx] = 1'b1;
			tbl_handle[idx] = h;
			tbl_sec[idx] = sec;
			tbl_ms[idx] = ms;
			tbl_timed[idx] = tk;
			res.slot = SLOT_W'(idx);
		end else begin
			for (int i = 0; i < ENTRIES; i++)
				if (tbl_valid[i] && tbl_handle[i] == h && idx < 0)
					idx = i;
			if (idx < 0) begin
				res.status = 1'b1;
			end else if (op == OP_LOOKUP) begin
				tbl_sec[idx] = sec;
				tbl_ms[idx] = ms;
				res.slot = SLOT_W'(idx);
			end else begin
				res.timer_trigger = tbl_timed[idx];
				tbl_valid[idx] = 1'b0;
				tbl_timed[idx] = 1'b0;
				res.slot = SLOT_W'(idx);
			end
		end
		return 1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		errors++;
	endtask

	task automatic check_result(input result_t want);
		if (status !== want.status)
			report_mismatch("status", 64'(status), 64'(want.status));
		if (slot !== want.slot)
			report_mismatch("slot", 64'(slot), 64'(want.slot));
		if (evicted !== want.evicted)
			report_mismatch("evicted", 64'(evicted), 64'(want.evicted));
		if (evicted_handle !== want.evicted_handle)
			report_mismatch("evicted_handle", evicted_handle, want.evicted_handle);
		if (timer_trigger !== want.timer_trigger)
			report_mismatch("timer_trigger", 64'(timer_trigger), 64'(want.timer_trigger));
		evictions_seen += want.evicted;
		misses_seen += want.status;
		triggers_seen += want.timer_trigger;
	endtask

	// values at the falling edge are those seen by the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0)
				report_mismatch("result with nothing pending, slot", 64'(slot), 64'(0));
			else
				check_result(pending_results.pop_front());
		end
	end

	always @(posedge clk) begin : rx_side
		int gap;
		if (gap == 0 && idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 11);
		out_ready <= !long_hold && gap == 0;
		if (gap > 0)
			gap--;
	end

	initial forever begin
		@(hold_start);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic send_item(input op_t op, input logic [HANDLE_W-1:0] h,
		input logic [SEC_W-1:0] sec, input logic [MS_W-1:0] ms, input logic tk);
		logic took;
		result_t res;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		handle <= h;
		now_seconds <= sec;
		now_millis <= ms;
		timed_key <= tk;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		if (predict_table(op, h, sec, ms, tk, res))
			pending_results.push_back(res);
		items_sent++;
	endtask

	task automatic rand_item(output bit counted);
		op_t op;
		int pick;
		logic [HANDLE_W-1:0] h;
		logic [SEC_W-1:0] sec;
		logic [MS_W-1:0] ms;
		pick = $urandom_range(0, 99);
		op = pick < 40 ? OP_START : pick < 72 ? OP_LOOKUP : pick < 92 ? OP_ABORT : OP_IGNORE;
		if (handle_pool.size() > 0 && (op == OP_START ? $urandom_range(0, 9) == 0
			: $urandom_range(0, 9) < 8)) begin
			h = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
		end else begin
			case ($urandom_range(0, 9))
				0: h = '0;
				1: h = '1;
				default: h = {$urandom, $urandom};
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			sec = $urandom;
		end else begin
			clock_sec += $urandom_range(0, 2);
			sec = clock_sec;
		end
		ms = $urandom_range(0, 9) == 0 ? MS_W'($urandom_range(1000, 1023))
			: MS_W'($urandom_range(0, 999));
		send_item(op, h, sec, ms, 1'($urandom_range(0, 1)));
		if (op == OP_START) begin
			handle_pool.push_back(h);
			if (handle_pool.size() > 24)
				void'(handle_pool.pop_front());
		end
		counted = op != OP_IGNORE;
	endtask

	task automatic run_random(input int n);
		int done;
		bit counted;
		done = 0;
		while (done < n) begin
			rand_item(counted);
			done += counted;
		end
	endtask

	task automatic test_empty_table;
		send_item(OP_LOOKUP, '0, '0, '0, 1'b0);
		send_item(OP_ABORT, '1, '1, '1, 1'b1);
		send_item(OP_IGNORE, '1, '1, '1, 1'b1);
	endtask

	// two oldest entries share a time, so the lower one goes first
	task automatic test_fill_and_evict;
		logic [HANDLE_W-1:0] dup;
		logic [HANDLE_W-1:0] h;
		logic [SEC_W-1:0] sec;
		logic [MS_W-1:0] ms;
		dup = {32'hA5A5_0000, 32'd4};
		for (int k = 0; k < ENTRIES; k++) begin
			h = k == 0 ? '1 : k == 9 ? dup : {32'hA5A5_0000, 32'(k)};
			sec = 1000 + k;
			ms = MS_W'(60 * k);
			if (k == 2 || k == 5) begin
				sec = '0;
				ms = '0;
			end else if (k == ENTRIES - 1) begin
				sec = '1;
				ms = '1;
			end
			send_item(OP_START, h, sec, ms, k[0]);
		end
		send_item(OP_START, 64'h0123_4567_89AB_CDEF, 32'd2000, 10'd0, 1'b1);
		send_item(OP_START, 64'hFEDC_BA98_7654_3210, 32'd2000, 10'd0, 1'b1);
		send_item(OP_LOOKUP, dup, 32'd3000, 10'd500, 1'b0);
		send_item(OP_ABORT, dup, 32'd3001, 10'd0, 1'b0);
		send_item(OP_ABORT, dup, 32'd3002, 10'd0, 1'b0);
		send_item(OP_START, 64'h5A5A_5A5A_5A5A_5A5A, 32'd3003, 10'd999, 1'b0);
	endtask

	task automatic test_output_hold_off;
		bit counted;
		idle_on <= 1'b0;
		-> hold_start;
		repeat (14)
			rand_item(counted);
		idle_on <= 1'b1;
	endtask

	task automatic test_random_traffic;
		run_random(390);
	endtask

	task automatic test_back_to_back;
		idle_on <= 1'b0;
		run_random(80);
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_timed[i] = 1'b0;
		end
		clock_sec = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table;
		test_fill_and_evict;
		test_output_hold_off;
		test_random_traffic;
		test_back_to_back;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d items sent, %0d results checked in %0d cycles", items_sent,
			results_seen, cycle_count);
		$display("%0d evictions, %0d misses, %0d timer triggers, %0d mismatches",
			evictions_seen, misses_seen, triggers_seen, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
